// ===== rtl/pca_pkg.sv =====
// Shared constants, types and codes for the pixel count accumulator.
// Depends on nothing; every other file of the block but pca_ram imports it.
package pca_pkg;

   // Store sizes
   localparam int unsigned MAX_PIXELS  = 65536;
   localparam int unsigned MAX_PACKETS = 4096;
   localparam int unsigned PIX_AW      = $clog2(MAX_PIXELS);
   localparam int unsigned PKT_AW      = $clog2(MAX_PACKETS);
   localparam int unsigned CLR_DEPTH   = (MAX_PIXELS > MAX_PACKETS) ? MAX_PIXELS : MAX_PACKETS;
   localparam int unsigned CLR_W       = $clog2(CLR_DEPTH);
   localparam int unsigned CLR_LAST    = CLR_DEPTH - 1;

   // Field widths
   localparam int unsigned ACTION_W = 3;
   localparam int unsigned PID_W    = 12;
   localparam int unsigned COORD_W  = 8;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned VALUE_W  = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned DIM_W    = 9;
   localparam int unsigned LIN_W    = 18;   // x + y*width with 8-bit x,y and 9-bit width
   localparam int unsigned DIM_RESET = 256;

   // Configuration port
   localparam int unsigned CSR_AW = 3;
   localparam int unsigned CSR_DW = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD    = 3'd0,
      ACT_EOI    = 3'd1,
      ACT_VERIFY = 3'd2,
      ACT_READ   = 3'd3,
      ACT_CLEAR  = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_COORD = 2'd1,
      STATUS_PKT   = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_WAIT,
      ST_VERIFY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
   } cfg_type;

   typedef struct packed {
      logic               img_rd;
      logic               img_we;
      logic [PIX_AW-1:0]  img_addr;
      logic [VALUE_W-1:0] img_wdata;
      logic               map_rd;
      logic               map_we;
      logic [PKT_AW-1:0]  map_addr;
      logic               map_wdata;
   } mem_ctl_type;

endpackage

// ===== rtl/pca_req_if.sv =====
// Request channel interface: valid/ready handshake plus the request word.
// Depends on pca_pkg for field widths.
interface pca_req_if;
   import pca_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [PID_W-1:0]    pkt_id;
   logic [COORD_W-1:0]  x;
   logic [COORD_W-1:0]  y;
   logic [COUNT_W-1:0]  hit_count;

   modport source (output valid, action, pkt_id, x, y, hit_count, input ready);
   modport sink   (input valid, action, pkt_id, x, y, hit_count, output ready);
endinterface

// ===== rtl/pca_rsp_if.sv =====
// Response channel interface: valid/ready handshake plus the result word.
// Depends on pca_pkg for field widths.
interface pca_rsp_if;
   import pca_pkg::*;

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  pixel_value;
   logic                verified;
   logic [STATUS_W-1:0] status;

   modport source (output valid, pixel_value, verified, status, input ready);
   modport sink   (input valid, pixel_value, verified, status, output ready);
endinterface

// ===== rtl/pca_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module pca_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/pca_csr.sv =====
// Configuration registers (image width and height) behind an APB-style port.
// Depends on pca_pkg.
module pca_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pca_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [pca_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [pca_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   output pca_pkg::cfg_type              cfg
);
   import pca_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             wr_hit;
   reg_index_type    reg_sel;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = reg_index_type'(csr_paddr[CSR_AW-1]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_hit) begin
         case (reg_sel)
            REG_WIDTH:  width_in  = csr_pwdata[DIM_W-1:0];
            REG_HEIGHT: height_in = csr_pwdata[DIM_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(DIM_RESET);
         height_ff <= DIM_W'(DIM_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign cfg.image_width  = width_ff;
   assign cfg.image_height = height_ff;
endmodule

// ===== rtl/pca_seq.sv =====
// Sequencer: decodes requests, drives the image and packet-map RAMs
// (read, modify, write back), walks the map for verify, sweeps for clear.
// Depends on pca_pkg, pca_req_if and pca_rsp_if.
module pca_seq (
   input  logic                         clock,
   input  logic                         reset,
   pca_req_if.sink                      req_ch,
   pca_rsp_if.source                    rsp_ch,
   input  pca_pkg::cfg_type             cfg,
   output pca_pkg::mem_ctl_type         mem,
   input  logic [pca_pkg::VALUE_W-1:0]  img_rdata,
   input  logic                         map_rdata
);
   import pca_pkg::*;

   state_type           state_ff, state_in;
   action_type          act_ff, act_in;
   status_type          status_ff, status_in;
   logic [PIX_AW-1:0]   addr_ff, addr_in;
   logic [PID_W-1:0]    pid_ff, pid_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [CLR_W-1:0]    clr_ff, clr_in;
   logic [PKT_AW:0]     walk_ff, walk_in;
   logic [PKT_AW:0]     lim_ff, lim_in;
   logic                reply_ff, reply_in;
   logic                eoi_valid_ff, eoi_valid_in;
   logic [PID_W-1:0]    eoi_id_ff, eoi_id_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic                res_ver_ff, res_ver_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_ver_ff, rsp_ver_in;
   status_type          rsp_status_ff, rsp_status_in;

   // Request decode
   logic                accept;
   logic [LIN_W-1:0]    lin_addr;
   logic [31:0]         lin32, pid32, req_pid32, clr32, eoi32, lim32;
   logic                coord_bad, pid_bad;
   status_type          dec_status;
   logic                slot_free;
   logic                clr_last;
   logic [PKT_AW:0]     walk_next;
   logic [VALUE_W-1:0]  sum;

   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign lin_addr  = LIN_W'(req_ch.x) + LIN_W'(req_ch.y) * LIN_W'(cfg.image_width);
   assign lin32     = 32'(lin_addr);
   assign req_pid32 = 32'(req_ch.pkt_id);
   assign pid32     = 32'(pid_ff);
   assign clr32     = 32'(clr_ff);
   assign eoi32     = 32'(eoi_id_ff);
   assign lim32     = (eoi32 < MAX_PACKETS) ? eoi32 : MAX_PACKETS;
   assign clr_last  = (clr_ff == CLR_W'(CLR_LAST));
   assign walk_next = walk_ff + 1'b1;
   assign sum       = img_rdata + cnt_ff;

   assign coord_bad = ({1'b0, req_ch.x} >= cfg.image_width)
                   || ({1'b0, req_ch.y} >= cfg.image_height)
                   || (lin32 >= MAX_PIXELS);
   assign pid_bad   = (req_pid32 >= MAX_PACKETS);

   always_comb begin
      case (action_type'(req_ch.action))
         ACT_ADD:  dec_status = coord_bad ? STATUS_COORD : (pid_bad ? STATUS_PKT : STATUS_OK);
         ACT_READ: dec_status = coord_bad ? STATUS_COORD : STATUS_OK;
         ACT_EOI:  dec_status = pid_bad ? STATUS_PKT : STATUS_OK;
         default:  dec_status = STATUS_OK;
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = reply_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (act_ff)
               ACT_ADD, ACT_READ: state_in = (status_ff == STATUS_OK) ? ST_WAIT : ST_FINISH;
               ACT_VERIFY:
                  state_in = (eoi_valid_ff && lim32 != 0) ? ST_VERIFY : ST_FINISH;
               ACT_CLEAR:         state_in = ST_CLEAR;
               default:           state_in = ST_FINISH;
            endcase
         end
         ST_WAIT: state_in = ST_FINISH;
         ST_VERIFY: begin
            if (!map_rdata || walk_next == lim_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      act_in        = act_ff;
      status_in     = status_ff;
      addr_in       = addr_ff;
      pid_in        = pid_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      walk_in       = walk_ff;
      lim_in        = lim_ff;
      reply_in      = reply_ff;
      eoi_valid_in  = eoi_valid_ff;
      eoi_id_in     = eoi_id_ff;
      res_value_in  = res_value_ff;
      res_ver_in    = res_ver_ff;
      res_status_in = res_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_ver_in    = rsp_ver_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      mem           = '0;
      mem.img_addr  = addr_ff;
      mem.map_addr  = pid32[PKT_AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            // sweep both stores, one entry a cycle
            mem.img_addr  = clr32[PIX_AW-1:0];
            mem.map_addr  = clr32[PKT_AW-1:0];
            mem.img_we    = (clr32 < MAX_PIXELS);
            mem.map_we    = (clr32 < MAX_PACKETS);
            mem.img_wdata = '0;
            mem.map_wdata = 1'b0;
            clr_in        = clr_ff + 1'b1;
            res_value_in  = '0;
            res_ver_in    = 1'b0;
            res_status_in = STATUS_OK;
         end
         ST_IDLE: begin
            if (accept) begin
               act_in    = action_type'(req_ch.action);
               status_in = dec_status;
               addr_in   = lin32[PIX_AW-1:0];
               pid_in    = req_ch.pkt_id;
               cnt_in    = req_ch.hit_count;
            end
         end
         ST_EXEC: begin
            res_value_in  = '0;
            res_ver_in    = 1'b0;
            res_status_in = status_ff;
            case (act_ff)
               ACT_ADD, ACT_READ: begin
                  mem.img_rd = (status_ff == STATUS_OK);
               end
               ACT_EOI: begin
                  if (status_ff == STATUS_OK) begin
                     eoi_valid_in = 1'b1;
                     eoi_id_in    = pid_ff;
                  end
               end
               ACT_VERIFY: begin
                  lim_in       = lim32[PKT_AW:0];
                  walk_in      = '0;
                  res_ver_in   = eoi_valid_ff && (lim32 == 0);
                  mem.map_rd   = eoi_valid_ff && (lim32 != 0);
                  mem.map_addr = '0;
               end
               ACT_CLEAR: begin
                  clr_in       = '0;
                  reply_in     = 1'b1;
                  eoi_valid_in = 1'b0;
                  eoi_id_in    = '0;
               end
               default: ;
            endcase
         end
         ST_WAIT: begin
            if (act_ff == ACT_ADD) begin
               // write back the sum and mark the packet
               mem.img_we    = 1'b1;
               mem.img_wdata = sum;
               mem.map_we    = 1'b1;
               mem.map_wdata = 1'b1;
               res_value_in  = sum;
            end else begin
               res_value_in  = img_rdata;
            end
         end
         ST_VERIFY: begin
            if (!map_rdata) begin
               res_ver_in = 1'b0;
            end else if (walk_next == lim_ff) begin
               res_ver_in = 1'b1;
            end else begin
               mem.map_rd   = 1'b1;
               mem.map_addr = walk_next[PKT_AW-1:0];
               walk_in      = walk_next;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_ver_in    = res_ver_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         reply_ff     <= 1'b0;
         eoi_valid_ff <= 1'b0;
         eoi_id_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         reply_ff     <= reply_in;
         eoi_valid_ff <= eoi_valid_in;
         eoi_id_ff    <= eoi_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      status_ff     <= status_in;
      addr_ff       <= addr_in;
      pid_ff        <= pid_in;
      cnt_ff        <= cnt_in;
      walk_ff       <= walk_in;
      lim_ff        <= lim_in;
      res_value_ff  <= res_value_in;
      res_ver_ff    <= res_ver_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_ver_ff    <= rsp_ver_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_value = rsp_value_ff;
   assign rsp_ch.verified    = rsp_ver_ff;
   assign rsp_ch.status      = rsp_status_ff;
endmodule

// ===== rtl/pixel_count_accumulator.sv =====
// Top level of the pixel count accumulator: sequencer, configuration registers
// and the two RAMs. Depends on pca_pkg, pca_req_if, pca_rsp_if, pca_ram,
// pca_csr and pca_seq.
//
// The block adds detector event counts into a 16-bit image held in a 65536-entry
// RAM and marks arrived packet IDs in a 4096-entry bitmap RAM. It handles one
// request word at a time and answers each with exactly one response word; a
// finished response waits in an output register, so the next request can be
// taken while the response is still pending. Steps from one accepted request
// to the next: an add or read of an in-range pixel goes through decode, RAM
// read, write back or capture and response load; end-of-image, unknown actions
// and an add or read with an out-of-range pixel go through decode, response
// load and accept; verify walks the bitmap RAM one entry a cycle, up to the
// end-of-image id or the first missing entry; clear sweeps both RAMs one entry
// a cycle. The response load waits while the output register stays full.
// After reset the same clearing sweep runs, during which no request is
// accepted; configuration writes are taken at any time. Image width and
// height lie at byte addresses 0 and 4.
module pixel_count_accumulator (
   input  logic                        clock,
   input  logic                        reset,
   pca_req_if.sink                     req_ch,
   pca_rsp_if.source                   rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pca_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [pca_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [pca_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import pca_pkg::*;

   cfg_type            cfg;
   mem_ctl_type        mem;
   logic [VALUE_W-1:0] img_rdata;
   logic               map_rdata;

   // Configuration registers
   pca_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Control: decode, read-modify-write, verify walk and clearing sweep
   pca_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .cfg       (cfg),
      .mem       (mem),
      .img_rdata (img_rdata),
      .map_rdata (map_rdata)
   );

   // Image store: one 16-bit count per pixel
   pca_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_PIXELS)
   ) u_img_ram (
      .clock (clock),
      .rd_en (mem.img_rd),
      .wr_en (mem.img_we),
      .addr  (mem.img_addr),
      .wdata (mem.img_wdata),
      .rdata (img_rdata)
   );

   // Packet map: one seen bit per packet id
   pca_ram #(
      .WIDTH (1),
      .DEPTH (MAX_PACKETS)
   ) u_map_ram (
      .clock (clock),
      .rd_en (mem.map_rd),
      .wr_en (mem.map_we),
      .addr  (mem.map_addr),
      .wdata (mem.map_wdata),
      .rdata (map_rdata)
   );
endmodule

// ===== sim/pixel_count_accumulator_test.sv =====
// Self-checking test of pixel_count_accumulator: a scoreboard class predicts every
// response word, plain tasks drive the request channel and the configuration port.
// Depends on pca_pkg, pca_req_if, pca_rsp_if and the block itself.

import pca_pkg::*;

typedef struct packed {
   logic [ACTION_W-1:0] action;
   logic [PID_W-1:0]    pkt_id;
   logic [COORD_W-1:0]  x;
   logic [COORD_W-1:0]  y;
   logic [COUNT_W-1:0]  hit_count;
} request_word;

typedef struct packed {
   logic [VALUE_W-1:0]  pixel_value;
   logic                verified;
   logic [STATUS_W-1:0] status;
} answer_word;

// Shadow copy of the image, the packet map and the end-of-image record, plus the
// queue of response words still owed by the block.
class pixel_scoreboard;
   localparam int REPORT_LIMIT = 10;

   bit [VALUE_W-1:0] image [MAX_PIXELS];
   bit               seen  [MAX_PACKETS];
   bit               eoi_recorded;
   bit [PID_W-1:0]   eoi_last;
   int unsigned      width;
   int unsigned      height;
   answer_word       answers_due [$];
   int               failures;
   int               answers_checked;
   int               requests_taken;
   int               action_hits [8];

   function new();
      width  = DIM_RESET;
      height = DIM_RESET;
      wipe();
   endfunction

   function void wipe();
      foreach (image[i]) image[i] = '0;
      foreach (seen[i]) seen[i] = 1'b0;
      eoi_recorded = 1'b0;
      eoi_last     = '0;
   endfunction

   function void set_dim(reg_index_type idx, logic [DIM_W-1:0] val);
      case (idx)
         REG_WIDTH:  width  = val;
         REG_HEIGHT: height = val;
         default: ;
      endcase
   endfunction

   function bit locate(bit [COORD_W-1:0] x, bit [COORD_W-1:0] y, output int unsigned addr);
      addr = 0;
      if (x >= width || y >= height)
         return 1'b0;
      addr = x + y * width;
      return addr < MAX_PIXELS;
   endfunction

   function bit all_seen_below(int unsigned lim);
      for (int unsigned i = 0; i < lim && i < MAX_PACKETS; i++)
         if (!seen[i])
            return 1'b0;
      return 1'b1;
   endfunction

   function answer_word accumulate_request(request_word w);
      answer_word  ans;
      int unsigned addr;
      ans = '0;
      case (w.action)
         ACT_ADD: begin
            if (!locate(w.x, w.y, addr))
               ans.status = STATUS_COORD;
            else if (w.pkt_id >= MAX_PACKETS)
               ans.status = STATUS_PKT;
            else begin
               image[addr]         = image[addr] + w.hit_count;
               seen[w.pkt_id]      = 1'b1;
               ans.pixel_value     = image[addr];
            end
         end
         ACT_EOI: begin
            if (w.pkt_id >= MAX_PACKETS)
               ans.status = STATUS_PKT;
            else begin
               eoi_recorded = 1'b1;
               eoi_last     = w.pkt_id;
            end
         end
         ACT_VERIFY: ans.verified = eoi_recorded && all_seen_below(eoi_last);
         ACT_READ: begin
            if (!locate(w.x, w.y, addr))
               ans.status = STATUS_COORD;
            else
               ans.pixel_value = image[addr];
         end
         ACT_CLEAR: wipe();
         default: ;
      endcase
      return ans;
   endfunction

   function void note_request(request_word w);
      answer_word want;
      requests_taken++;
      action_hits[w.action]++;
      want        = accumulate_request(w);
      answers_due = {answers_due, want};
   endfunction

   function void record_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("MISMATCH: %s", msg);
   endfunction

   function void check_answer(answer_word got);
      answer_word want;
      answers_checked++;
      if (answers_due.size() == 0) begin
         record_failure($sformatf("unexpected response: value %h verified %b status %0d",
                                  got.pixel_value, got.verified, got.status));
         return;
      end
      want = answers_due.pop_front();
      if (got.pixel_value !== want.pixel_value || got.verified !== want.verified ||
          got.status !== want.status)
         record_failure($sformatf({"response %0d: expected value %h verified %b status %0d,",
                                   " got value %h verified %b status %0d"},
                                  answers_checked, want.pixel_value, want.verified,
                                  want.status, got.pixel_value, got.verified, got.status));
   endfunction

   function int pending();
      return answers_due.size();
   endfunction
endclass

module pixel_count_accumulator_test;

   // No word moving for this long means a hang; the limit must outlast a clear sweep.
   localparam int STALL_LIMIT      = 300000;
   localparam int HOLD_CYCLES      = 400;
   localparam int SETTLE_CYCLES    = 16;
   localparam int BUSY_PCT         = 25;
   localparam int UNUSED_ACTION_LO = 5;
   localparam int UNUSED_ACTION_HI = 7;
   localparam int RANDOM_CLEARS    = 3;
   localparam int PID_RESTART      = 3000;

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   pca_req_if req_ch ();
   pca_rsp_if rsp_ch ();

   pixel_scoreboard    sb;
   int                 idle_pct;
   int                 stall_pct;
   logic               hold_rsp;
   int                 next_pid;
   int                 clears_left;
   int                 dims_applied;
   int                 quiet_cycles = 0;
   logic [COORD_W-1:0] hot_x;
   logic [COORD_W-1:0] hot_y;

   pixel_count_accumulator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Response side: stall at random, or hold off entirely while hold_rsp is set.
   initial begin : rsp_pacing
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Sample both channels with the values that stood at the edge. A response
   // taken at the same edge as a request belongs to an older word, so check
   // it first. Any handshake counts as progress for the watchdog.
   always @(posedge clock) begin : word_monitor
      request_word taken;
      answer_word  got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.pixel_value = rsp_ch.pixel_value;
            got.verified    = rsp_ch.verified;
            got.status      = rsp_ch.status;
            sb.check_answer(got);
         end
         if (req_ch.valid && req_ch.ready) begin
            taken.action    = req_ch.action;
            taken.pkt_id    = req_ch.pkt_id;
            taken.x         = req_ch.x;
            taken.y         = req_ch.y;
            taken.hit_count = req_ch.hit_count;
            sb.note_request(taken);
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles, %0d responses outstanding",
                  quiet_cycles, sb.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offer one request word, with random idle cycles ahead of it, and hold it
   // until the block takes it. Valid stays high on return so a following word
   // goes out back to back.
   task automatic send_request(input logic [ACTION_W-1:0] act, input logic [PID_W-1:0] pid,
                               input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                               input logic [COUNT_W-1:0] cnt);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.pkt_id    <= pid;
      req_ch.x         <= px;
      req_ch.y         <= py;
      req_ch.hit_count <= cnt;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid and wait until every response has come back, then let the
   // block settle.
   task automatic wait_for_answers();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write followed by a read back of the same register; the bus idles
   // before the next transfer.
   task automatic write_register(input reg_index_type idx, input logic [DIM_W-1:0] val);
      logic [CSR_DW-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(4 * int'(idx));
      csr_pwdata  <= CSR_DW'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_dim(idx, val);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== CSR_DW'(val))
         sb.record_failure($sformatf("register %0d read back %h, wrote %h",
                                     int'(idx), readback, val));
      @(posedge clock);
   endtask

   // Change the image size only with the block idle.
   task automatic apply_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      wait_for_answers();
      write_register(REG_WIDTH, w);
      write_register(REG_HEIGHT, h);
      dims_applied++;
   endtask

   function automatic logic [COORD_W-1:0] pick_axis(int unsigned dim);
      if (dim == 0)
         return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
      return COORD_W'($urandom_range(0, ((dim > (1 << COORD_W)) ? (1 << COORD_W) : dim) - 1));
   endfunction

   // Mostly in-range pixels, often the same one again so counts pile up and wrap,
   // now and then anywhere in the 8-bit coordinate space.
   function automatic void pick_pixel(output logic [COORD_W-1:0] px,
                                      output logic [COORD_W-1:0] py);
      if ($urandom_range(0, 2) == 0) begin
         px = hot_x;
         py = hot_y;
      end else if ($urandom_range(0, 9) == 0) begin
         px = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
         py = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
      end else begin
         px = pick_axis(sb.width);
         py = pick_axis(sb.height);
      end
      hot_x = px;
      hot_y = py;
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
      endcase
   endfunction

   // One random phase. Most of it is frames: a run of adds over consecutive
   // packet ids (sometimes with one missing), then an end-of-image id and a
   // verify. The rest is pixel reads, noise, pauses and the odd clear.
   task automatic run_phase(input int n_items, input bit quiet);
      int                 issued;
      int                 n;
      int                 gap_at;
      int                 ofs;
      int unsigned        eoi;
      bit                 descending;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      issued    = 0;
      idle_pct  = quiet ? 0 : BUSY_PCT;
      stall_pct <= quiet ? 0 : BUSY_PCT;
      // Hold the response side off so the block backs up and stalls requests.
      if (!quiet)
         fork
            begin
               hold_rsp <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_rsp <= 1'b0;
            end
         join_none
      while (issued < n_items) begin
         case ($urandom_range(0, 99)) inside
            [0:59]: begin
               n          = $urandom_range(1, 12);
               gap_at     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
               descending = $urandom_range(0, 1);
               for (int k = 0; k < n; k++) begin
                  ofs = descending ? n - 1 - k : k;
                  if (ofs != gap_at) begin
                     pick_pixel(px, py);
                     send_request(ACT_ADD, PID_W'(next_pid + ofs), px, py, pick_count());
                  end
               end
               case ($urandom_range(0, 19))
                  0: eoi = $urandom_range(0, MAX_PACKETS - 1);
                  1: eoi = $urandom_range(0, next_pid + n);
                  default: eoi = next_pid + n;
               endcase
               send_request(ACT_EOI, PID_W'(eoi), px, py, pick_count());
               send_request(ACT_VERIFY, PID_W'($urandom), px, py, pick_count());
               next_pid += n;
               if (next_pid > PID_RESTART)
                  next_pid = 0;
               issued += n + 2;
            end
            [60:79]: begin
               repeat ($urandom_range(1, 4)) begin
                  pick_pixel(px, py);
                  send_request(ACT_READ, PID_W'($urandom), px, py, pick_count());
                  issued++;
               end
            end
            [80:89]: begin
               px = COORD_W'($urandom);
               py = COORD_W'($urandom);
               case ($urandom_range(0, 4))
                  // Unknown codes change no state but still get a response and count as work.
                  0: send_request(ACTION_W'($urandom_range(UNUSED_ACTION_LO, UNUSED_ACTION_HI)),
                                  PID_W'($urandom), px, py, pick_count());
                  1: send_request(ACT_ADD, PID_W'($urandom), px, py, pick_count());
                  2: send_request(ACT_READ, PID_W'($urandom), px, py, pick_count());
                  3: send_request(ACT_EOI, PID_W'($urandom), px, py, pick_count());
                  default: send_request(ACT_VERIFY, PID_W'($urandom), px, py, pick_count());
               endcase
               issued++;
            end
            [90:94]: wait_for_answers();
            default: begin
               // A clear sweeps 64k entries, so only RANDOM_CLEARS of them over all phases.
               if (clears_left > 0) begin
                  send_request(ACT_CLEAR, PID_W'($urandom), COORD_W'($urandom),
                               COORD_W'($urandom), pick_count());
                  clears_left--;
                  next_pid = 0;
               end else
                  send_request(ACT_VERIFY, PID_W'($urandom), COORD_W'($urandom),
                               COORD_W'($urandom), pick_count());
               issued++;
            end
         endcase
      end
   endtask

   initial begin : stimulus
      sb = new();
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.action      <= ACT_ADD;
      req_ch.pkt_id      <= '0;
      req_ch.x           <= '0;
      req_ch.y           <= '0;
      req_ch.hit_count   <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      hold_rsp           <= 1'b0;
      stall_pct          <= BUSY_PCT;
      idle_pct     = BUSY_PCT;
      next_pid     = 0;
      clears_left  = RANDOM_CLEARS;
      dims_applied = 0;
      hot_x        = '0;
      hot_y        = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset image size of 256 x 256. The block runs its
      // clearing sweep first; the first word simply waits for it.
      send_request(ACT_VERIFY, '0, '0, '0, '0);      // no end-of-image yet
      send_request(ACT_READ, '0, '0, '0, '0);
      send_request(ACT_ADD, '0, '0, '0, '1);
      send_request(ACT_ADD, '1, '1, '1, 16'd1);      // far corner, top packet id
      send_request(ACT_ADD, 12'd1, '0, '0, 16'd1);   // wraps to zero
      send_request(ACT_ADD, 12'd2, '0, '0, '0);
      send_request(ACT_READ, '1, '1, '1, '1);
      send_request(ACT_READ, '0, '0, '0, '0);
      send_request(ACT_EOI, '0, '0, '0, '0);
      send_request(ACT_VERIFY, '0, '0, '0, '0);      // end-of-image id zero passes at once
      send_request(ACT_EOI, 12'd3, '1, '1, '1);
      send_request(ACT_VERIFY, '1, '1, '1, '1);      // ids below 3 all present; id 3 itself is not checked
      send_request(ACT_ADD, 12'd3, 8'd128, 8'd64, 16'h8000);
      send_request(ACT_VERIFY, '0, '0, '0, '0);
      for (int a = UNUSED_ACTION_LO; a <= UNUSED_ACTION_HI; a++)
         send_request(ACTION_W'(a), '1, '1, '1, '1);
      send_request(ACT_EOI, '1, '0, '0, '0);
      send_request(ACT_VERIFY, '0, '0, '0, '0);
      send_request(ACT_CLEAR, '1, '1, '1, '1);
      send_request(ACT_VERIFY, '0, '0, '0, '0);      // end-of-image forgotten
      send_request(ACT_READ, '0, '1, '1, '0);
      send_request(ACT_READ, '0, 8'd128, 8'd64, '0);

      // Random phases over a spread of image sizes, from the full frame down to
      // zero rows or columns, and a width whose rows run past the image store.
      apply_dims(9'd256, 9'd256);
      run_phase(300, 1'b0);
      apply_dims(9'd17, 9'd9);
      run_phase(200, 1'b1);
      apply_dims(9'd511, 9'd200);
      run_phase(150, 1'b0);
      apply_dims(9'd1, 9'd1);
      run_phase(100, 1'b0);
      apply_dims(9'd0, 9'd5);
      run_phase(40, 1'b0);
      apply_dims(9'd5, 9'd0);
      run_phase(30, 1'b0);
      apply_dims(9'd256, 9'd1);
      run_phase(100, 1'b0);
      apply_dims(9'd3, 9'd256);
      run_phase(100, 1'b0);
      wait_for_answers();

      $display("Took %0d request words: %0d add, %0d end-of-image, %0d verify, %0d read, %0d clear",
               sb.requests_taken, sb.action_hits[ACT_ADD], sb.action_hits[ACT_EOI],
               sb.action_hits[ACT_VERIFY], sb.action_hits[ACT_READ], sb.action_hits[ACT_CLEAR]);
      $display("Checked %0d response words over %0d image sizes; %0d mismatches",
               sb.answers_checked, dims_applied, sb.failures);
      if (sb.failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
